### rtl/gocg_pkg.sv
// Shared types and constants of the gyro offset calibration and gate unit.
package gocg_pkg;

  localparam int CAL_SAMPLES = 100;
  localparam int CAL_PAIRS   = CAL_SAMPLES / 2;
  localparam int POS_W       = $clog2(CAL_SAMPLES + 1);

  localparam int SMP_W   = 16;
  localparam int IVL_W   = 32;
  localparam int RATE_W  = 15;
  localparam int STOT_W  = 23;
  localparam int ITOT_W  = 38;
  localparam int LIM_W   = 33;
  // Six times an interval total: the interval limit kept in scaled form
  localparam int LIMX_W  = ITOT_W + 3;

  // Offset quotient |S| / CAL_PAIRS by multiplication with a rounded-up reciprocal
  localparam int OFF_NUM_W       = 22;
  localparam int OFF_RECIP_SHIFT = 28;
  localparam int OFF_RECIP_W     = 29;
  localparam logic [OFF_RECIP_W-1:0] OFF_RECIP =
    OFF_RECIP_W'(((64'd1 << OFF_RECIP_SHIFT) + 64'(CAL_PAIRS) - 64'd1) / 64'(CAL_PAIRS));

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RATE_CAP = 2'd0,
    REG_BIAS_CAP = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic signed [SMP_W-1:0] sample;
    logic [IVL_W-1:0]        interval_us;
  } in_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] rate;
    logic                    calibrated;
    logic                    cal_error;
  } out_t;

  // One classified item as it waits between front and back
  typedef struct packed {
    logic signed [SMP_W-1:0] sample;
    logic [IVL_W-1:0]        interval_us;
    logic                    pair;
    logic                    batch_end;
    logic signed [SMP_W-1:0] pair_smp;
    logic [IVL_W-1:0]        pair_ivl;
  } entry_t;

endpackage

### rtl/gocg_fifo.sv
// Short queue of classified items between front and back.
module gocg_fifo import gocg_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   wr_i,
  input  entry_t wr_data_i,
  input  logic   rd_i,
  output entry_t rd_data_o,
  output logic   full_o,
  output logic   empty_o
);

  entry_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]  count_q, count_d;

  assign full_o    = (count_q == QCNT_W'(QDEPTH));
  assign empty_o   = (count_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_i ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = rd_i ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    if (wr_i && !rd_i) begin
      count_d = count_q + QCNT_W'(1);
    end else if (!wr_i && rd_i) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QDEPTH))
    else $error("queue count beyond depth");

  a_write_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i |-> !full_o || rd_i)
    else $error("write into a full queue");

endmodule

### rtl/gocg_div.sv
// Division of a batch sum magnitude by the pair count, by reciprocal multiplication.
module gocg_div import gocg_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [OFF_NUM_W-1:0] num_i,
  output logic                 busy_o,
  output logic [SMP_W-1:0]     quo_o
);

  logic                               busy_q;
  logic [OFF_NUM_W-1:0]               num_q;
  logic [OFF_NUM_W+OFF_RECIP_W-1:0]   prod;

  // Quotient is valid in the cycle after start, while busy_o is high
  assign prod   = {{OFF_RECIP_W{1'b0}}, num_q} * {{OFF_NUM_W{1'b0}}, OFF_RECIP};
  assign quo_o  = prod[OFF_RECIP_SHIFT +: SMP_W];
  assign busy_o = busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
    end
  end

endmodule

### rtl/gocg_front.sv
// Front end: takes items in, tracks batch position and forms pair averages.
module gocg_front import gocg_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   accept_i,
  input  in_t    in_i,
  output entry_t entry_o
);

  logic [POS_W-1:0]        pos_q, pos_d;
  logic [POS_W-1:0]        pos_next;
  logic signed [SMP_W-1:0] held_smp_q;
  logic [IVL_W-1:0]        held_ivl_q;
  logic signed [SMP_W:0]   smp_sum;
  logic signed [SMP_W:0]   smp_avg;
  logic [IVL_W:0]          ivl_sum;
  logic                    is_end;

  always_comb begin
    pos_next = pos_q + POS_W'(1);
    is_end   = (pos_next == POS_W'(CAL_SAMPLES));
    pos_d    = is_end ? '0 : pos_next;
    smp_sum  = {held_smp_q[SMP_W-1], held_smp_q} + {in_i.sample[SMP_W-1], in_i.sample};
    // round toward zero: bias negative sums by one before the shift
    smp_avg  = (smp_sum + {{SMP_W{1'b0}}, smp_sum[SMP_W]}) >>> 1;
    ivl_sum  = {1'b0, held_ivl_q} + {1'b0, in_i.interval_us};

    entry_o.sample      = in_i.sample;
    entry_o.interval_us = in_i.interval_us;
    entry_o.pair        = !pos_next[0];
    entry_o.batch_end   = is_end;
    entry_o.pair_smp    = smp_avg[SMP_W-1:0];
    entry_o.pair_ivl    = ivl_sum[IVL_W:1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      held_smp_q <= '0;
      held_ivl_q <= '0;
    end else if (accept_i) begin
      pos_q <= pos_d;
      if (pos_next[0]) begin
        held_smp_q <= in_i.sample;
        held_ivl_q <= in_i.interval_us;
      end
    end
  end

endmodule

### rtl/gocg_back.sv
// Back end: accumulates batches, sets offset and limit, gates the rate.
module gocg_back import gocg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [RATE_W-1:0] rate_cap_i,
  input  logic [RATE_W-1:0] bias_cap_i,
  input  entry_t            q_head_i,
  input  logic              q_empty_i,
  output logic              q_rd_o,
  input  logic              pop,
  output logic              empty,
  output out_t              out_o
);

  logic                     cal_q;
  logic signed [SMP_W-1:0]  off_q;
  logic [LIMX_W-1:0]        lim6_q;
  logic signed [STOT_W-1:0] stot_q;
  logic [ITOT_W-1:0]        itot_q;
  logic                     ok_q, neg_q;
  logic                     out_valid_q;
  out_t                     out_q;

  logic signed [SMP_W:0]    diff;
  logic [SMP_W:0]           diff_mag;
  logic [LIMX_W-1:0]        ivl_scaled;
  logic                     gate_ok;
  logic signed [STOT_W-1:0] s_new;
  logic [ITOT_W-1:0]        t_new;
  logic [LIMX_W-1:0]        t6_new;
  logic [STOT_W-1:0]        s_mag;
  logic [STOT_W-1:0]        bound;
  logic                     fail;
  logic [SMP_W-1:0]         quo_off;
  logic                     busy, start;
  out_t                     res;

  assign q_rd_o = !q_empty_i && !busy && (!out_valid_q || pop);
  assign start  = q_rd_o && !cal_q && q_head_i.batch_end;

  always_comb begin
    diff     = {q_head_i.sample[SMP_W-1], q_head_i.sample} - {off_q[SMP_W-1], off_q};
    diff_mag = diff[SMP_W] ? -diff : diff;
    // interval <= floor(6T / 5P) holds exactly when 5P * interval <= 6T
    ivl_scaled = LIMX_W'(q_head_i.interval_us) * LIMX_W'(5 * CAL_PAIRS);
    gate_ok  = (diff_mag <= {2'b0, rate_cap_i}) && (ivl_scaled <= lim6_q);

    s_new = stot_q;
    t_new = itot_q;
    if (q_head_i.pair) begin
      s_new = stot_q + {{(STOT_W-SMP_W){q_head_i.pair_smp[SMP_W-1]}}, q_head_i.pair_smp};
      t_new = itot_q + {{(ITOT_W-IVL_W){1'b0}}, q_head_i.pair_ivl};
    end
    s_mag = s_new[STOT_W-1] ? -s_new : s_new;
    bound = STOT_W'({{(STOT_W-RATE_W){1'b0}}, bias_cap_i} * STOT_W'(CAL_PAIRS));
    fail  = (s_mag > bound);

    // 6*T as 4*T + 2*T
    t6_new = (LIMX_W'(t_new) << 2) + (LIMX_W'(t_new) << 1);

    res.rate       = (cal_q && gate_ok) ? diff[SMP_W-1:0] : '0;
    res.calibrated = cal_q || (q_head_i.batch_end && !fail);
    res.cal_error  = !cal_q && q_head_i.batch_end && fail;
  end

  gocg_div u_div_off (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .num_i   (OFF_NUM_W'(s_mag)),
    .busy_o  (busy),
    .quo_o   (quo_off)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q       <= 1'b0;
      off_q       <= '0;
      lim6_q      <= '0;
      stot_q      <= '0;
      itot_q      <= '0;
      ok_q        <= 1'b0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_rd_o && !cal_q) begin
        if (q_head_i.batch_end) begin
          stot_q <= '0;
          itot_q <= '0;
          off_q  <= '0;
          lim6_q <= t6_new;
          ok_q   <= !fail;
          neg_q  <= s_new[STOT_W-1];
        end else begin
          stot_q <= s_new;
          itot_q <= t_new;
        end
      end
      if (busy && ok_q) begin
        off_q <= neg_q ? -quo_off : quo_off;
        cal_q <= 1'b1;
      end
      if (q_rd_o) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_rd_o) begin
      out_q <= res;
    end
  end

  assign empty = !out_valid_q;
  assign out_o = out_q;

  a_cal_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cal_q |=> cal_q)
    else $error("calibration lost");

  a_limit_only_on_batch_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !start |=> $stable(lim6_q))
    else $error("interval limit changed outside a batch end");

  a_stall_after_batch_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> busy)
    else $error("offset division not started at batch end");

  a_no_take_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !q_rd_o)
    else $error("item taken while division runs");

endmodule

### rtl/gyro_offset_calibrate_and_gate_unit.sv
// Top level of the gyro offset calibration and gate unit.
// With the queue empty, an item is written into the queue, then its result into the result register.
// Throughput: one item per cycle while results are popped; the item that ends a calibration
//   batch holds the back end while the offset is formed by reciprocal multiplication.
// Reset: queue and result register empty, not calibrated, totals, offset, limit zero, caps 32767.
module gyro_offset_calibrate_and_gate_unit import gocg_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  in_t                  in_data_i,
  output logic                 empty,
  input  logic                 pop,
  output out_t                 out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [RATE_W-1:0]    cfg_wdata_i
);

  logic [RATE_W-1:0] rate_cap_q;
  logic [RATE_W-1:0] bias_cap_q;
  logic              accept;
  entry_t            entry;
  entry_t            q_head;
  logic              q_empty;
  logic              q_rd;

  // Transfer in whenever the queue has room; the back end drains it on its own
  assign accept = push && !full;

  // Configuration writes; indexes past the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_cap_q <= {RATE_W{1'b1}};
      bias_cap_q <= {RATE_W{1'b1}};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_RATE_CAP: rate_cap_q <= cfg_wdata_i;
        REG_BIAS_CAP: bias_cap_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Front: batch position and pair averages, independent of calibration state
  gocg_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .in_i     (in_data_i),
    .entry_o  (entry)
  );

  // Queue decouples the input side from back-end stalls
  gocg_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (accept),
    .wr_data_i (entry),
    .rd_i      (q_rd),
    .rd_data_o (q_head),
    .full_o    (full),
    .empty_o   (q_empty)
  );

  // Back: calibration arithmetic, gating and the result register
  gocg_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rate_cap_i (rate_cap_q),
    .bias_cap_i (bias_cap_q),
    .q_head_i   (q_head),
    .q_empty_i  (q_empty),
    .q_rd_o     (q_rd),
    .pop        (pop),
    .empty      (empty),
    .out_o      (out_data_o)
  );

endmodule
